@@ rtl/core/pidr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_pkg: shared types and constants of the drift rate PI controller
// Payload structs, register indexes and reset values, fixed-point widths and
// the request/status structs of the serial multiplier and ratio divider.
// ----------------------------------------------------------------------------
package pidr_pkg;

   // Field widths
   localparam int CORR_W     = 32;   // signed corrections, ppm * 2^-16
   localparam int MAXC_W     = 31;
   localparam int THR_W      = 31;
   localparam int GAIN_W     = 32;
   localparam int LIM_W      = 48;
   localparam int DT_W       = 24;
   localparam int RATIO_W    = 48;
   localparam int PHASE_W    = 32;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CORRECTION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESYNC_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_GAIN          = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KI_GAIN          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_LIMIT   = 3'd4;

   localparam logic [MAXC_W-1:0] MAXC_RESET = 31'd32768000;
   localparam logic [THR_W-1:0]  THR_RESET  = 31'd5000;
   localparam logic [GAIN_W-1:0] KP_RESET   = 32'd1677722;
   localparam logic [GAIN_W-1:0] KI_RESET   = 32'd167772;
   localparam logic [LIM_W-1:0]  LIM_RESET  = 48'd3276800000;

   // Function codes
   localparam logic [1:0] FUNC_UPDATE = 2'd0;
   localparam logic [1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [1:0] FUNC_RESET  = 2'd2;

   // Fixed-point constants
   localparam logic [DT_W-1:0]    DT_LIMIT   = 24'h05_0000;        // 5 s, Q16
   localparam logic [RATIO_W-1:0] RATIO_ONE  = 48'h0100_0000_0000; // 1.0, Q40
   localparam int                 PPM_SCALE  = 1000000;

   // Internal datapath widths
   localparam int INT_W      = LIM_W + 1;         // integral, |x| <= limit
   localparam int DTPROD_W   = 50;                // |phase| * dt < 2^50
   localparam int ACC_W      = DTPROD_W + 2;      // integral plus increment
   localparam int KP_SHIFT   = 8;
   localparam int KI_SHIFT   = 24;
   localparam int PPROD_W    = 55;                // (kp * |phase|) >> 8
   localparam int PTERM_W    = PPROD_W + 1;
   localparam int MUL_A_W    = 48;
   localparam int MUL_B_W    = 32;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int IPROD_W    = MUL_P_W - KI_SHIFT;
   localparam int PI_W       = IPROD_W + 2;       // signed sum of both terms
   localparam int CMAG_W     = CORR_W - 1;        // magnitude of a correction
   localparam int RATIO_SH   = 24;                // total * 2^24 / 1e6
   localparam int DIV_Q_W    = 36;                // quotient < 2^36
   localparam int DIV_REM_W  = 20;                // remainder < 1e6 < 2^20

   typedef struct packed {
      logic [1:0]                 func;
      logic signed [PHASE_W-1:0]  phase_offset;
      logic signed [CORR_W-1:0]   skew_corr;
      logic [DT_W-1:0]            dt_sec;
   } req_type;

   typedef struct packed {
      logic [RATIO_W-1:0]         rate_ratio;
      logic signed [CORR_W-1:0]   dynamic_correction;
      logic signed [CORR_W-1:0]   total_correction;
      logic                       resync_needed;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [MUL_A_W-1:0]   mcand;
      logic [MUL_B_W-1:0]   mplier;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [MUL_P_W-1:0]   product;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [CMAG_W-1:0]    mag;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_Q_W-1:0]   quot;
   } div_rsp_type;

endpackage

@@ rtl/core/pidr_serial_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_serial_mul: bit-serial shift-and-add multiplier
// Unsigned 48 x 32 multiply, one multiplier bit per cycle, LSB first. The
// product appears with a one-cycle done pulse once the last bit is shifted in.
// ----------------------------------------------------------------------------
module pidr_serial_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  pidr_pkg::mul_req_type mul_req,
   output pidr_pkg::mul_rsp_type mul_rsp
);
   import pidr_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic [MUL_P_W-1:0] prod_ff, prod_in;
   logic [MUL_A_W-1:0] mcand_ff, mcand_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_A_W:0]   upper_sum;

   // Upper half of the running product plus the multiplicand when the
   // current multiplier bit is set.
   assign upper_sum = {1'b0, prod_ff[MUL_P_W-1:MUL_B_W]}
                    + (prod_ff[0] ? {1'b0, mcand_ff} : {(MUL_A_W+1){1'b0}});

   // Next-state logic: load on start, otherwise shift one bit per cycle while busy.
   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         mcand_in = mul_req.mcand;
         prod_in  = {{MUL_A_W{1'b0}}, mul_req.mplier};
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in  = {upper_sum, prod_ff[MUL_B_W-1:1]};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(MUL_B_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

endmodule

@@ rtl/core/pidr_ppm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidr_ppm_div: serial divider for the ppm-to-ratio conversion
// Computes floor(mag * 2^24 / 1000000) by restoring division, one quotient
// bit per cycle. The top numerator bits are preloaded into the remainder,
// since they lie below the divisor, which leaves 36 steps.
// ----------------------------------------------------------------------------
module pidr_ppm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  pidr_pkg::div_req_type div_req,
   output pidr_pkg::div_rsp_type div_rsp
);
   import pidr_pkg::*;

   localparam int PRE_W = CMAG_W + RATIO_SH - DIV_Q_W;   // preloaded bits
   localparam int LOW_W = CMAG_W - PRE_W;                // mag bits shifted in
   localparam int CNT_W = $clog2(DIV_Q_W);
   localparam logic [DIV_REM_W:0] DIVISOR = (DIV_REM_W+1)'(PPM_SCALE);

   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_Q_W-1:0]   shift_ff, shift_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_REM_W:0]   partial;
   logic [DIV_REM_W:0]   trial;
   logic                 fits;

   // Bring down the next numerator bit and try to subtract the divisor.
   assign partial = {rem_ff, shift_ff[DIV_Q_W-1]};
   assign trial   = partial - DIVISOR;
   assign fits    = (partial >= DIVISOR);

   // Numerator bits leave the top of the shift register while quotient
   // bits enter at the bottom.
   always_comb begin
      rem_in   = rem_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = {{(DIV_REM_W-PRE_W){1'b0}}, div_req.mag[CMAG_W-1 -: PRE_W]};
         shift_in = {div_req.mag[LOW_W-1:0], {RATIO_SH{1'b0}}};
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial[DIV_REM_W-1:0] : partial[DIV_REM_W-1:0];
         shift_in = {shift_ff[DIV_Q_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(DIV_Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = shift_ff;

endmodule

@@ rtl/core/pi_drift_rate_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pi_drift_rate_controller: PI loop steering an audio resampler against drift
// Every request transaction returns exactly one response transaction with the
// held ratio, corrections and sticky resync flag after the request is applied.
// A full update request passes through acceptance, the threshold check, the
// phase-times-dt product and its clamp, the proportional and the integral
// products, saturation of their sum, the total correction, the ratio
// conversion and the hand-off to the response register. The three products
// run one after another in one shared bit-serial multiplier, and the ratio
// conversion runs in a bit-serial divider. When dt is zero or at least 5 s
// the phase-times-dt product and its clamp are skipped. An update that trips
// the resync threshold goes from the threshold check straight to the
// hand-off, and a clear, reset or unused request goes from acceptance
// straight to the hand-off. One request is in work at a time; a new one is
// accepted as soon as the previous one has moved to the response register,
// even if that response has not yet been taken.
// ----------------------------------------------------------------------------
module pi_drift_rate_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pidr_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pidr_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [pidr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pidr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_INTEG,
      S_CLAMP,
      S_PTERM,
      S_ITERM,
      S_DYN,
      S_TOT,
      S_RATIO,
      S_DIV,
      S_RESP
   } state_type;

   // Configuration registers
   logic [MAXC_W-1:0]  max_corr_ff;
   logic [THR_W-1:0]   thr_ff;
   logic [GAIN_W-1:0]  kp_ff;
   logic [GAIN_W-1:0]  ki_ff;
   logic [LIM_W-1:0]   int_lim_ff;

   // Control and loop state
   state_type                 state_ff, state_in;
   logic                      flag_ff, flag_in;
   logic signed [INT_W-1:0]   integral_ff, integral_in;
   logic signed [CORR_W-1:0]  dyn_ff, dyn_in;
   logic signed [CORR_W-1:0]  tot_ff, tot_in;
   logic [RATIO_W-1:0]        ratio_ff, ratio_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Per-transaction payload
   logic                      phase_neg_ff, phase_neg_in;
   logic [PHASE_W-1:0]        pmag_ff, pmag_in;
   logic signed [CORR_W-1:0]  skew_ff, skew_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PTERM_W-1:0] pterm_ff, pterm_in;
   logic signed [PI_W-1:0]    pi_sum_ff, pi_sum_in;
   rsp_type                   rsp_data_ff, rsp_data_in;

   // Datapath helpers
   logic [PHASE_W-1:0]        phase_bits;
   logic [INT_W-1:0]          int_bits;
   logic [INT_W-1:0]          imag_full;
   logic [CORR_W-1:0]         tot_bits;
   logic [CORR_W-1:0]         tmag_full;
   logic signed [ACC_W-1:0]   acc_lim;
   logic signed [ACC_W-1:0]   acc_clamped;
   logic signed [PI_W-1:0]    pi_lim;
   logic signed [PI_W-1:0]    pi_clamped;
   logic signed [CORR_W:0]    tot_sum;
   logic signed [CORR_W:0]    tot_lim;
   logic signed [CORR_W:0]    tot_clamped;
   logic signed [ACC_W-1:0]   dt_prod;
   logic signed [PTERM_W-1:0] pprod;
   logic signed [PI_W-1:0]    iprod;
   logic signed [PI_W-1:0]    pterm_ext;
   logic                      dt_ok;

   mul_req_type mul_req;
   mul_rsp_type mul_rsp;
   div_req_type div_req;
   div_rsp_type div_rsp;

   pidr_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   pidr_ppm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration writes; indexes beyond the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_corr_ff <= MAXC_RESET;
         thr_ff      <= THR_RESET;
         kp_ff       <= KP_RESET;
         ki_ff       <= KI_RESET;
         int_lim_ff  <= LIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_CORRECTION:   max_corr_ff <= csr_wdata[MAXC_W-1:0];
            CSR_RESYNC_THRESHOLD: thr_ff      <= csr_wdata[THR_W-1:0];
            CSR_KP_GAIN:          kp_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_KI_GAIN:          ki_ff       <= csr_wdata[GAIN_W-1:0];
            CSR_INTEGRAL_LIMIT:   int_lim_ff  <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Magnitudes of the incoming phase, the integral and the total.
   assign phase_bits = req_data.phase_offset;
   assign int_bits   = integral_ff;
   assign imag_full  = int_bits[INT_W-1] ? (~int_bits + 1'b1) : int_bits;
   assign tot_bits   = tot_ff;
   assign tmag_full  = tot_bits[CORR_W-1] ? (~tot_bits + 1'b1) : tot_bits;

   // Signed products taken from the multiplier, with the phase or integral
   // sign applied.
   assign dt_prod = phase_neg_ff
                  ? -$signed({{(ACC_W-DTPROD_W){1'b0}}, mul_rsp.product[DTPROD_W-1:0]})
                  :  $signed({{(ACC_W-DTPROD_W){1'b0}}, mul_rsp.product[DTPROD_W-1:0]});
   assign pprod   = phase_neg_ff
                  ? -$signed({1'b0, mul_rsp.product[KP_SHIFT +: PPROD_W]})
                  :  $signed({1'b0, mul_rsp.product[KP_SHIFT +: PPROD_W]});
   assign iprod   = int_bits[INT_W-1]
                  ? -$signed({{(PI_W-IPROD_W){1'b0}}, mul_rsp.product[MUL_P_W-1:KI_SHIFT]})
                  :  $signed({{(PI_W-IPROD_W){1'b0}}, mul_rsp.product[MUL_P_W-1:KI_SHIFT]});
   assign pterm_ext = $signed({{(PI_W-PTERM_W){pterm_ff[PTERM_W-1]}}, pterm_ff});

   assign dt_ok = (dt_ff != '0) && (dt_ff < DT_LIMIT);

   // Anti-windup clamp of the accumulated integral.
   always_comb begin
      acc_lim = $signed({{(ACC_W-LIM_W){1'b0}}, int_lim_ff});
      if (acc_ff > acc_lim) begin
         acc_clamped = acc_lim;
      end else if (acc_ff < -acc_lim) begin
         acc_clamped = -acc_lim;
      end else begin
         acc_clamped = acc_ff;
      end
   end

   // Saturation of the PI sum to the correction limit.
   always_comb begin
      pi_lim = $signed({{(PI_W-MAXC_W){1'b0}}, max_corr_ff});
      if (pi_sum_ff > pi_lim) begin
         pi_clamped = pi_lim;
      end else if (pi_sum_ff < -pi_lim) begin
         pi_clamped = -pi_lim;
      end else begin
         pi_clamped = pi_sum_ff;
      end
   end

   // Skew plus dynamic correction, saturated to the same limit.
   always_comb begin
      tot_sum = $signed({skew_ff[CORR_W-1], skew_ff}) + $signed({dyn_ff[CORR_W-1], dyn_ff});
      tot_lim = $signed({{(CORR_W+1-MAXC_W){1'b0}}, max_corr_ff});
      if (tot_sum > tot_lim) begin
         tot_clamped = tot_lim;
      end else if (tot_sum < -tot_lim) begin
         tot_clamped = -tot_lim;
      end else begin
         tot_clamped = tot_sum;
      end
   end

   // Sequencer: walks one request at a time through the shared serial multiplier and the serial divider.
   always_comb begin
      state_in     = state_ff;
      flag_in      = flag_ff;
      integral_in  = integral_ff;
      dyn_in       = dyn_ff;
      tot_in       = tot_ff;
      ratio_in     = ratio_ff;
      rsp_valid_in = rsp_valid_ff;
      phase_neg_in = phase_neg_ff;
      pmag_in      = pmag_ff;
      skew_in      = skew_ff;
      dt_in        = dt_ff;
      acc_in       = acc_ff;
      pterm_in     = pterm_ff;
      pi_sum_in    = pi_sum_ff;
      rsp_data_in  = rsp_data_ff;

      mul_req.start  = 1'b0;
      mul_req.mcand  = {{(MUL_A_W-CMAG_W){1'b0}}, pmag_ff[CMAG_W-1:0]};
      mul_req.mplier = kp_ff;
      div_req.start  = 1'b0;
      div_req.mag    = tmag_full[CMAG_W-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_RESP;
               unique case (req_data.func)
                  FUNC_UPDATE: begin
                     phase_neg_in = phase_bits[PHASE_W-1];
                     pmag_in      = phase_bits[PHASE_W-1] ? (~phase_bits + 1'b1)
                                                          : phase_bits;
                     skew_in      = req_data.skew_corr;
                     dt_in        = req_data.dt_sec;
                     state_in     = S_CHECK;
                  end
                  FUNC_CLEAR: begin
                     flag_in = 1'b0;
                  end
                  FUNC_RESET: begin
                     integral_in = '0;
                     dyn_in      = '0;
                     tot_in      = '0;
                     ratio_in    = RATIO_ONE;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            if (pmag_ff > {1'b0, thr_ff}) begin
               // Hard resync: sticky flag and loop reset, no PI step.
               flag_in     = 1'b1;
               integral_in = '0;
               dyn_in      = '0;
               tot_in      = '0;
               ratio_in    = RATIO_ONE;
               state_in    = S_RESP;
            end else if (dt_ok) begin
               mul_req.start  = 1'b1;
               mul_req.mplier = {{(MUL_B_W-DT_W){1'b0}}, dt_ff};
               state_in       = S_INTEG;
            end else begin
               mul_req.start = 1'b1;
               state_in      = S_PTERM;
            end
         end
         S_INTEG: begin
            if (mul_rsp.done) begin
               acc_in   = $signed({{(ACC_W-INT_W){integral_ff[INT_W-1]}}, integral_ff})
                        + dt_prod;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            integral_in   = acc_clamped[INT_W-1:0];
            mul_req.start = 1'b1;
            state_in      = S_PTERM;
         end
         S_PTERM: begin
            if (mul_rsp.done) begin
               pterm_in       = pprod;
               mul_req.start  = 1'b1;
               mul_req.mcand  = imag_full[MUL_A_W-1:0];
               mul_req.mplier = ki_ff;
               state_in       = S_ITERM;
            end
         end
         S_ITERM: begin
            if (mul_rsp.done) begin
               pi_sum_in = pterm_ext + iprod;
               state_in  = S_DYN;
            end
         end
         S_DYN: begin
            dyn_in   = pi_clamped[CORR_W-1:0];
            state_in = S_TOT;
         end
         S_TOT: begin
            tot_in   = tot_clamped[CORR_W-1:0];
            state_in = S_RATIO;
         end
         S_RATIO: begin
            div_req.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               ratio_in = tot_ff[CORR_W-1]
                        ? RATIO_ONE - {{(RATIO_W-DIV_Q_W){1'b0}}, div_rsp.quot}
                        : RATIO_ONE + {{(RATIO_W-DIV_Q_W){1'b0}}, div_rsp.quot};
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // Move the held values into the response register once it is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.rate_ratio         = ratio_ff;
               rsp_data_in.dynamic_correction = dyn_ff;
               rsp_data_in.total_correction   = tot_ff;
               rsp_data_in.resync_needed      = flag_ff;
               state_in                       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      phase_neg_ff <= phase_neg_in;
      pmag_ff      <= pmag_in;
      skew_ff      <= skew_in;
      dt_ff        <= dt_in;
      acc_ff       <= acc_in;
      pterm_ff     <= pterm_in;
      pi_sum_ff    <= pi_sum_in;
      rsp_data_ff  <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         flag_ff      <= 1'b0;
         integral_ff  <= '0;
         dyn_ff       <= '0;
         tot_ff       <= '0;
         ratio_ff     <= RATIO_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flag_ff      <= flag_in;
         integral_ff  <= integral_in;
         dyn_ff       <= dyn_in;
         tot_ff       <= tot_in;
         ratio_ff     <= ratio_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // The multiplier finishes only while the sequencer waits for a product.
   a_mul_done_expected: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == S_INTEG || state_ff == S_PTERM || state_ff == S_ITERM))
      else $error("multiplier result arrived outside a product wait state");

   // The divider finishes only while the sequencer waits for the ratio.
   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV))
      else $error("divider result arrived outside the ratio wait state");

   // A reported ratio lies below one exactly when the total correction is negative.
   a_ratio_sign: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> (tot_ff[CORR_W-1] == (ratio_ff < RATIO_ONE)))
      else $error("ratio and total correction disagree in sign");
`endif

endmodule
